[hdl/bitmap_run_block_allocator_macros.svh]
// assertion macros for the bitmap run block allocator
// no dependencies; expects clk and rst_n in the including scope
`ifndef BITMAP_RUN_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BMRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bmra check failed");
`define BMRA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bmra reset check failed");
`else
`define BMRA_ASSERT(lbl, prop)
`define BMRA_ASSERT_RST(lbl, prop)
`endif
`endif

[hdl/bmra_pkg.sv]
// shared types, codes and bit functions of the bitmap run block allocator
// no dependencies
package bmra_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int MAX_RUNS_DEF   = 63;
  localparam int WORD_BITS      = 64;

  localparam int SHIFT_W  = 5;
  localparam int LIMIT_W  = 13;
  localparam int SIZE_W   = 32;
  localparam int RUNS_W   = 6;
  localparam int OFF_W    = 40;
  localparam int STATUS_W = 3;
  localparam int START_W  = 12;
  localparam int USED_W   = 13;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  localparam logic CFG_SHIFT = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_START_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SIZE_RANGE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FREED       = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_EVAL_ALLOC,
    OP_EVAL_FREE,
    OP_WRD_RD,
    OP_WRD_CHK,
    OP_CAND,
    OP_CHK_RD,
    OP_CHK_USE,
    OP_SET_RD,
    OP_SET_WR,
    OP_GRANT,
    OP_ADV,
    OP_DONE,
    OP_FR_RD,
    OP_FR_WR,
    OP_FREE_OUT,
    OP_ERR_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic alloc_ok;
    logic fr_err;
    logic fr_zero;
    logic w_end;
    logic word_full;
    logic cand_over;
    logic hit;
    logic hit_leave;
    logic x_last;
    logic all_granted;
    logic adv_done;
    logic adv_same;
    logic out_free;
  } dp_stat_t;

  function automatic logic [WORD_BITS-1:0] range_mask(input logic [5:0] lo,
                                                      input logic [5:0] hi);
    return ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (6'd63 - hi));
  endfunction

  function automatic logic [5:0] ffs64(input logic [WORD_BITS-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [6:0] popcnt64(input logic [WORD_BITS-1:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

endpackage

[hdl/bitmap_run_block_allocator.sv]
// top level of the bitmap run block allocator: sequencer plus datapath
// depends on bmra_pkg, bmra_ctrl, bmra_dp and bitmap_run_block_allocator_macros.svh
//
// Input channel (in_*): one beat is an allocate (in_cmd 0) or a free (in_cmd 1).
// An allocate returns one beat per granted run (status 0) and then a done beat
// with the run count and out_last set; a free returns one beat with out_last set.
// Every result carries the blocks-in-use count after that result.
// Config channel (cfg_*): always ready; index 0 block shift, index 1 pool size.
// One item is worked at a time; in_ready is high only between items.
// Sequence: a free is decoded and checked, then each bitmap word it touches is read and
// written back, then its result beat is sent. An allocate is decoded and checked, then
// the search reads and tests each word it visits, takes each candidate start and reads
// and tests each word the candidate spans; per grant it reads and marks each word, sends
// the grant beat and advances before the next candidate; the done beat comes last.
// Each word access is a read state then a use or write state, as the memory read is registered.
// Reset: the used-bit memory is swept to zero, one word per cycle, with in_ready low;
// config writes go on.
// Output stall: results sit in an output register; the sequencer waits there
// while out_ready is low, and a new item can be taken while the last result waits.
`include "bitmap_run_block_allocator_macros.svh"

module bitmap_run_block_allocator #(
  parameter int NUM_BLOCKS = bmra_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_RUNS   = bmra_pkg::MAX_RUNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [bmra_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [bmra_pkg::RUNS_W-1:0]   in_run_count,
  input  logic [bmra_pkg::OFF_W-1:0]    in_offset_bytes,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmra_pkg::STATUS_W-1:0] out_status,
  output logic [bmra_pkg::START_W-1:0]  out_start_block,
  output logic [bmra_pkg::RUNS_W-1:0]   out_granted_runs,
  output logic [bmra_pkg::USED_W-1:0]   out_blocks_used,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [bmra_pkg::LIMIT_W-1:0]  cfg_data
);

  bmra_pkg::dp_cmd_t  cmd;
  bmra_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bmra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmra_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_RUNS   (MAX_RUNS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_size_bytes    (in_size_bytes),
    .in_run_count     (in_run_count),
    .in_offset_bytes  (in_offset_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_start_block  (out_start_block),
    .out_granted_runs (out_granted_runs),
    .out_blocks_used  (out_blocks_used),
    .out_last         (out_last)
  );

  `BMRA_ASSERT_RST(a_sweep_after_reset, !rst_n |=> !in_ready)
  `BMRA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
  `BMRA_ASSERT(a_grant_not_last, out_valid && out_status == bmra_pkg::ST_GRANT |-> !out_last)
  `BMRA_ASSERT(a_used_in_pool, out_valid |-> 32'(out_blocks_used) <= NUM_BLOCKS)

endmodule

[hdl/bmra_ctrl.sv]
// sequencer of the bitmap run block allocator
// depends on bmra_pkg; drives bmra_dp through command and status structs
module bmra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmra_pkg::dp_stat_t stat,
  output bmra_pkg::dp_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_INIT     = 18'h00001,
    S_IDLE     = 18'h00002,
    S_DECODE   = 18'h00004,
    S_EVAL     = 18'h00008,
    S_WRD_RD   = 18'h00010,
    S_WRD_CHK  = 18'h00020,
    S_CAND     = 18'h00040,
    S_CHK_RD   = 18'h00080,
    S_CHK_USE  = 18'h00100,
    S_SET_RD   = 18'h00200,
    S_SET_WR   = 18'h00400,
    S_GRANT    = 18'h00800,
    S_ADV      = 18'h01000,
    S_DONE     = 18'h02000,
    S_FR_RD    = 18'h04000,
    S_FR_WR    = 18'h08000,
    S_FREE_OUT = 18'h10000,
    S_ERR_OUT  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bmra_pkg::OP_NONE;
    case (state_r)
      S_INIT: begin
        cmd.op = bmra_pkg::OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bmra_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op    = bmra_pkg::OP_DECODE;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.is_free) begin
          if (stat.alloc_ok) begin
            cmd.op    = bmra_pkg::OP_EVAL_ALLOC;
            state_nxt = S_WRD_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.fr_err) begin
          state_nxt = S_ERR_OUT;
        end else if (stat.fr_zero) begin
          state_nxt = S_FREE_OUT;
        end else begin
          cmd.op    = bmra_pkg::OP_EVAL_FREE;
          state_nxt = S_FR_RD;
        end
      end
      S_WRD_RD: begin
        if (stat.w_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = bmra_pkg::OP_WRD_RD;
          state_nxt = S_WRD_CHK;
        end
      end
      S_WRD_CHK: begin
        cmd.op    = bmra_pkg::OP_WRD_CHK;
        state_nxt = stat.word_full ? S_WRD_RD : S_CAND;
      end
      S_CAND: begin
        cmd.op    = bmra_pkg::OP_CAND;
        state_nxt = stat.cand_over ? S_DONE : S_CHK_RD;
      end
      S_CHK_RD: begin
        cmd.op    = bmra_pkg::OP_CHK_RD;
        state_nxt = S_CHK_USE;
      end
      S_CHK_USE: begin
        cmd.op = bmra_pkg::OP_CHK_USE;
        if (stat.hit) begin
          state_nxt = stat.hit_leave ? S_WRD_RD : S_CAND;
        end else begin
          state_nxt = stat.x_last ? S_SET_RD : S_CHK_RD;
        end
      end
      S_SET_RD: begin
        cmd.op    = bmra_pkg::OP_SET_RD;
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.op    = bmra_pkg::OP_SET_WR;
        state_nxt = stat.x_last ? S_GRANT : S_SET_RD;
      end
      S_GRANT: begin
        if (stat.out_free) begin
          cmd.op    = bmra_pkg::OP_GRANT;
          state_nxt = stat.all_granted ? S_DONE : S_ADV;
        end
      end
      S_ADV: begin
        cmd.op = bmra_pkg::OP_ADV;
        if (stat.adv_done) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = stat.adv_same ? S_CAND : S_WRD_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = bmra_pkg::OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_FR_RD: begin
        cmd.op    = bmra_pkg::OP_FR_RD;
        state_nxt = S_FR_WR;
      end
      S_FR_WR: begin
        cmd.op    = bmra_pkg::OP_FR_WR;
        state_nxt = stat.x_last ? S_FREE_OUT : S_FR_RD;
      end
      S_FREE_OUT: begin
        if (stat.out_free) begin
          cmd.op    = bmra_pkg::OP_FREE_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_ERR_OUT: begin
        if (stat.out_free) begin
          cmd.op    = bmra_pkg::OP_ERR_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/bmra_dp.sv]
// datapath of the bitmap run block allocator: used-bit memory, search and range
// registers, usage count, config registers and result register; depends on bmra_pkg
module bmra_dp #(
  parameter int NUM_BLOCKS = bmra_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_RUNS   = bmra_pkg::MAX_RUNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmra_pkg::dp_cmd_t                 cmd,
  output bmra_pkg::dp_stat_t                stat,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bmra_pkg::LIMIT_W-1:0]      cfg_data,
  input  logic                              in_cmd,
  input  logic [bmra_pkg::SIZE_W-1:0]       in_size_bytes,
  input  logic [bmra_pkg::RUNS_W-1:0]       in_run_count,
  input  logic [bmra_pkg::OFF_W-1:0]        in_offset_bytes,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bmra_pkg::STATUS_W-1:0]     out_status,
  output logic [bmra_pkg::START_W-1:0]      out_start_block,
  output logic [bmra_pkg::RUNS_W-1:0]       out_granted_runs,
  output logic [bmra_pkg::USED_W-1:0]       out_blocks_used,
  output logic                              out_last
);

  localparam int WB        = bmra_pkg::WORD_BITS;
  localparam int NUM_WORDS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WCNT_W    = WIDX_W + 1;
  localparam int BLK_W     = WIDX_W + 6;
  localparam int CNT_W     = BLK_W + 1;
  localparam int SUM_W     = CNT_W + 1;
  localparam int SIZE_W    = bmra_pkg::SIZE_W;
  localparam int OFF_W     = bmra_pkg::OFF_W;
  localparam int RUNS_W    = bmra_pkg::RUNS_W;

  logic [WB-1:0]     mem [NUM_WORDS];
  logic [WB-1:0]     rdata_r;
  logic              rd_en, we;
  logic [WIDX_W-1:0] raddr, waddr;
  logic [WB-1:0]     wdata;

  logic [bmra_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [bmra_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [WIDX_W-1:0] clr_r, clr_nxt;
  logic [WIDX_W-1:0] search_r, search_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              cmd_r, cmd_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [RUNS_W-1:0] runs_r, runs_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [SIZE_W-1:0] blk_r, blk_nxt;
  logic [OFF_W-1:0]  ostart_r, ostart_nxt;
  logic              mis_r, mis_nxt;
  logic [CNT_W-1:0]  req_r, req_nxt;
  logic [WCNT_W-1:0] w_r, w_nxt;
  logic [BLK_W-1:0]  c_r, c_nxt;
  logic [WIDX_W-1:0] x_r, x_nxt;
  logic [BLK_W-1:0]  rs_r, rs_nxt;
  logic [BLK_W-1:0]  re_r, re_nxt;
  logic [RUNS_W-1:0] granted_r, granted_nxt;
  logic              dbl_r, dbl_nxt;

  logic [bmra_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [bmra_pkg::START_W-1:0]  ostb_r, ostb_nxt;
  logic [RUNS_W-1:0]             ogr_r, ogr_nxt;
  logic [bmra_pkg::USED_W-1:0]   oused_r, oused_nxt;
  logic                          olast_r, olast_nxt;

  logic [CNT_W-1:0]  total;
  logic [RUNS_W-1:0] wanted;
  logic [SIZE_W:0]   blk_sum;
  logic              start_bad, size_bad;
  logic [bmra_pkg::STATUS_W-1:0] err_code;
  logic [OFF_W:0]    fr_end;
  logic [SUM_W-1:0]  cand_sum;
  logic [5:0]        lo, hi;
  logic [WB-1:0]     mask, hits;
  logic [BLK_W-1:0]  p;
  logic [CNT_W-1:0]  req_m1, lim, kmax;
  logic [SUM_W-1:0]  adv_sum;
  logic [6:0]        pc;
  logic              out_load;

  assign total  = (32'(limit_r) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(limit_r);
  assign wanted = (32'(runs_r) > MAX_RUNS) ? RUNS_W'(MAX_RUNS) : runs_r;

  assign blk_sum = {1'b0, size_r} + ((SIZE_W + 1)'(1) << shift_r) - (SIZE_W + 1)'(1);

  assign start_bad = ostart_r >= OFF_W'(total);
  assign size_bad  = ({1'b0, ostart_r} + (OFF_W + 1)'(blk_r)) > (OFF_W + 1)'(total);
  assign err_code  = mis_r ? bmra_pkg::ST_MISALIGN :
                     start_bad ? bmra_pkg::ST_START_RANGE : bmra_pkg::ST_SIZE_RANGE;
  assign fr_end    = {1'b0, ostart_r} + (OFF_W + 1)'(blk_r) - (OFF_W + 1)'(1);

  assign cand_sum = SUM_W'(c_r) + SUM_W'(req_r);

  assign lo   = (x_r == rs_r[BLK_W-1:6]) ? rs_r[5:0] : 6'd0;
  assign hi   = (x_r == re_r[BLK_W-1:6]) ? re_r[5:0] : 6'd63;
  assign mask = bmra_pkg::range_mask(lo, hi);
  assign hits = rdata_r & mask;
  assign p    = {x_r, bmra_pkg::ffs64(hits)};
  assign pc   = bmra_pkg::popcnt64(hits);

  assign req_m1  = req_r - CNT_W'(1);
  assign lim     = CNT_W'(6'd63 - c_r[5:0]);
  assign kmax    = (req_m1 < lim) ? req_m1 : lim;
  assign adv_sum = SUM_W'(c_r) + SUM_W'(kmax) + SUM_W'(req_r);

  always_comb begin
    stat.clr_last    = (clr_r == WIDX_W'(NUM_WORDS - 1));
    stat.is_free     = (cmd_r == bmra_pkg::CMD_FREE);
    stat.alloc_ok    = (blk_r != '0) && ((SIZE_W + 1)'(blk_r) <= (SIZE_W + 1)'(total))
                       && (wanted != '0);
    stat.fr_err      = mis_r || start_bad || size_bad;
    stat.fr_zero     = (blk_r == '0);
    stat.w_end       = (w_r == WCNT_W'(NUM_WORDS));
    stat.word_full   = &rdata_r;
    stat.cand_over   = cand_sum > SUM_W'(total);
    stat.hit         = |hits;
    stat.hit_leave   = (p[BLK_W-1:6] != w_r[WIDX_W-1:0]) || (&p[5:0]);
    stat.x_last      = (x_r == re_r[BLK_W-1:6]);
    stat.all_granted = ((RUNS_W + 1)'(granted_r) + (RUNS_W + 1)'(1)) == (RUNS_W + 1)'(wanted);
    stat.adv_done    = (kmax != '0) && (adv_sum > SUM_W'(total));
    stat.adv_same    = (SUM_W'(c_r[5:0]) + SUM_W'(req_r)) <= SUM_W'(63);
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    shift_nxt   = shift_r;
    limit_nxt   = limit_r;
    clr_nxt     = clr_r;
    search_nxt  = search_r;
    used_nxt    = used_r;
    cmd_nxt     = cmd_r;
    size_nxt    = size_r;
    runs_nxt    = runs_r;
    off_nxt     = off_r;
    blk_nxt     = blk_r;
    ostart_nxt  = ostart_r;
    mis_nxt     = mis_r;
    req_nxt     = req_r;
    w_nxt       = w_r;
    c_nxt       = c_r;
    x_nxt       = x_r;
    rs_nxt      = rs_r;
    re_nxt      = re_r;
    granted_nxt = granted_r;
    dbl_nxt     = dbl_r;
    ost_nxt     = ost_r;
    ostb_nxt    = ostb_r;
    ogr_nxt     = ogr_r;
    oused_nxt   = oused_r;
    olast_nxt   = olast_r;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    raddr       = x_r;
    we          = 1'b0;
    waddr       = x_r;
    wdata       = rdata_r;

    if (cfg_we) begin
      if (cfg_index == bmra_pkg::CFG_SHIFT) begin
        shift_nxt = cfg_data[bmra_pkg::SHIFT_W-1:0];
      end else begin
        limit_nxt = cfg_data;
      end
    end

    case (cmd.op)
      bmra_pkg::OP_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + WIDX_W'(1);
      end
      bmra_pkg::OP_LOAD: begin
        cmd_nxt  = in_cmd;
        size_nxt = in_size_bytes;
        runs_nxt = in_run_count;
        off_nxt  = in_offset_bytes;
      end
      bmra_pkg::OP_DECODE: begin
        blk_nxt     = SIZE_W'(blk_sum >> shift_r);
        ostart_nxt  = off_r >> shift_r;
        mis_nxt     = |(off_r & ((OFF_W'(1) << shift_r) - OFF_W'(1)));
        granted_nxt = '0;
        dbl_nxt     = 1'b0;
      end
      bmra_pkg::OP_EVAL_ALLOC: begin
        req_nxt = CNT_W'(blk_r);
        w_nxt   = {1'b0, search_r};
      end
      bmra_pkg::OP_EVAL_FREE: begin
        rs_nxt = BLK_W'(ostart_r);
        re_nxt = BLK_W'(fr_end);
        x_nxt  = ostart_r[BLK_W-1:6];
      end
      bmra_pkg::OP_WRD_RD: begin
        rd_en = 1'b1;
        raddr = w_r[WIDX_W-1:0];
      end
      bmra_pkg::OP_WRD_CHK: begin
        if (&rdata_r) begin
          w_nxt = w_r + WCNT_W'(1);
        end else begin
          c_nxt = {w_r[WIDX_W-1:0], bmra_pkg::ffs64(~rdata_r)};
        end
      end
      bmra_pkg::OP_CAND: begin
        rs_nxt = c_r;
        re_nxt = BLK_W'(cand_sum - SUM_W'(1));
        x_nxt  = c_r[BLK_W-1:6];
      end
      bmra_pkg::OP_CHK_RD, bmra_pkg::OP_SET_RD, bmra_pkg::OP_FR_RD: begin
        rd_en = 1'b1;
      end
      bmra_pkg::OP_CHK_USE: begin
        if (|hits) begin
          if (stat.hit_leave) begin
            w_nxt = w_r + WCNT_W'(1);
          end else begin
            c_nxt = p + BLK_W'(1);
          end
        end else if (stat.x_last) begin
          x_nxt = rs_r[BLK_W-1:6];
        end else begin
          x_nxt = x_r + WIDX_W'(1);
        end
      end
      bmra_pkg::OP_SET_WR: begin
        we    = 1'b1;
        wdata = rdata_r | mask;
        if (stat.x_last) begin
          used_nxt   = used_r + req_r;
          search_nxt = w_r[WIDX_W-1:0];
        end else begin
          x_nxt = x_r + WIDX_W'(1);
        end
      end
      bmra_pkg::OP_GRANT: begin
        out_load    = 1'b1;
        ost_nxt     = bmra_pkg::ST_GRANT;
        ostb_nxt    = bmra_pkg::START_W'(c_r);
        ogr_nxt     = '0;
        olast_nxt   = 1'b0;
        granted_nxt = granted_r + RUNS_W'(1);
      end
      bmra_pkg::OP_ADV: begin
        if (!stat.adv_done) begin
          if (stat.adv_same) begin
            c_nxt = BLK_W'(cand_sum);
          end else begin
            w_nxt = w_r + WCNT_W'(1);
          end
        end
      end
      bmra_pkg::OP_DONE: begin
        out_load  = 1'b1;
        ost_nxt   = bmra_pkg::ST_DONE;
        ostb_nxt  = '0;
        ogr_nxt   = granted_r;
        olast_nxt = 1'b1;
      end
      bmra_pkg::OP_FR_WR: begin
        we       = 1'b1;
        wdata    = rdata_r & ~mask;
        dbl_nxt  = dbl_r | (|(~rdata_r & mask));
        used_nxt = (used_r > CNT_W'(pc)) ? used_r - CNT_W'(pc) : '0;
        if (!stat.x_last) begin
          x_nxt = x_r + WIDX_W'(1);
        end
      end
      bmra_pkg::OP_FREE_OUT: begin
        out_load  = 1'b1;
        ost_nxt   = dbl_r ? bmra_pkg::ST_DOUBLE_FREE : bmra_pkg::ST_FREED;
        ostb_nxt  = bmra_pkg::START_W'(ostart_r);
        ogr_nxt   = '0;
        olast_nxt = 1'b1;
      end
      bmra_pkg::OP_ERR_OUT: begin
        out_load  = 1'b1;
        ost_nxt   = err_code;
        ostb_nxt  = '0;
        ogr_nxt   = '0;
        olast_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    // usage count is captured with the beat so a stalled beat keeps its value
    if (out_load) begin
      oused_nxt = bmra_pkg::USED_W'(used_r);
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= bmra_pkg::SHIFT_RST;
      limit_r     <= bmra_pkg::LIMIT_RST;
      clr_r       <= '0;
      search_r    <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      limit_r     <= limit_nxt;
      clr_r       <= clr_nxt;
      search_r    <= search_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    size_r    <= size_nxt;
    runs_r    <= runs_nxt;
    off_r     <= off_nxt;
    blk_r     <= blk_nxt;
    ostart_r  <= ostart_nxt;
    mis_r     <= mis_nxt;
    req_r     <= req_nxt;
    w_r       <= w_nxt;
    c_r       <= c_nxt;
    x_r       <= x_nxt;
    rs_r      <= rs_nxt;
    re_r      <= re_nxt;
    granted_r <= granted_nxt;
    dbl_r     <= dbl_nxt;
    ost_r     <= ost_nxt;
    ostb_r    <= ostb_nxt;
    ogr_r     <= ogr_nxt;
    oused_r   <= oused_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = ost_r;
  assign out_start_block  = ostb_r;
  assign out_granted_runs = ogr_r;
  assign out_blocks_used  = oused_r;
  assign out_last         = olast_r;

endmodule
